// File: design/wav_header_and_sample_parser_unit_macros.svh
// Assertion helpers for the WAV parser, clocked on i_clk, off during reset.
`ifndef WAV_HEADER_AND_SAMPLE_PARSER_UNIT_MACROS_SVH
`define WAV_HEADER_AND_SAMPLE_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define WAVP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WAVP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/wavp_pkg.sv
package wavp_pkg;

    localparam logic [7:0]  CH_D     = 8'h64;
    localparam logic [7:0]  CH_A     = 8'h61;
    localparam logic [7:0]  CH_T     = 8'h74;
    localparam logic [31:0] DATA_TAG = 32'h64617461;

    localparam logic [3:0] FLD_LAST_FIXED = 4'd10;
    localparam logic [3:0] FLD_DATA_TAG   = 4'd11;
    localparam logic [3:0] FLD_DATA_SIZE  = 4'd12;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // byte from the input side, tagged with the compares the scanner needs
    typedef struct packed {
        logic [7:0] data;
        logic       sof;
        logic       is_d;
        logic       eq_a;
        logic       eq_t;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [3:0]         field_id;
        logic [31:0]        field_value;
        logic signed [15:0] sample_value;
        logic               last_sample;
    } t_result;

    typedef enum logic [4:0] {
        S_HDR   = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DSIZE = 5'b00100,
        S_SAMP  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // RIFF, WAVE and fmt tags are packed big-endian
    function automatic logic fld_is_tag(input logic [3:0] fld);
        return (fld == 4'd0) || (fld == 4'd2) || (fld == 4'd3);
    endfunction

    // two-byte fields: format, channels, block align, bits per sample
    function automatic logic fld_is_short(input logic [3:0] fld);
        return (fld == 4'd5) || (fld == 4'd6) || (fld == 4'd9) || (fld == 4'd10);
    endfunction

endpackage

// File: design/wavp_front.sv
module wavp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [7:0]     i_data_byte,
    input  logic           i_start_of_file,
    output logic           o_full,
    output logic           o_valid,
    output wavp_pkg::t_item o_item,
    input  logic           i_take
);
    import wavp_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_item       w_item;
    logic        w_wr, w_rd;

    always_comb begin
        w_item.data = i_data_byte;
        w_item.sof  = i_start_of_file;
        w_item.is_d = (i_data_byte == CH_D);
        w_item.eq_a = (i_data_byte == CH_A);
        w_item.eq_t = (i_data_byte == CH_T);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// File: design/wavp_outq.sv
module wavp_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  wavp_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    output wavp_pkg::t_result o_head,
    input  logic             i_pop
);
    import wavp_pkg::*;

    t_result     r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];
    assign w_rd    = i_pop && !o_empty;
    assign w_wr    = i_wr && (!o_full || w_rd);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

// File: design/wavp_back.sv
module wavp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wavp_pkg::t_item   i_item,
    output logic              o_take,
    input  logic              i_out_ready,
    output logic              o_res_valid,
    output wavp_pkg::t_result o_res
);
    import wavp_pkg::*;

    t_state      r_state, n_state;
    logic [3:0]  r_fld, n_fld;
    logic [1:0]  r_pos, n_pos;
    logic [31:0] r_acc, n_acc;
    logic        r_match, n_match;
    logic [30:0] r_rem, n_rem;
    logic [7:0]  r_held, n_held;

    // start_of_file restarts the parse with this byte
    t_state      e_state;
    logic [3:0]  e_fld;
    logic [1:0]  e_pos;
    logic [31:0] e_acc;
    logic        e_match;
    logic [30:0] e_rem;
    logic [31:0] w_le_acc;
    logic        w_tail_ok;
    logic        w_emit;
    t_result     w_res;

    assign o_take = i_valid && i_out_ready;

    always_comb begin
        e_state = i_item.sof ? S_HDR : r_state;
        e_fld   = i_item.sof ? 4'd0  : r_fld;
        e_pos   = i_item.sof ? 2'd0  : r_pos;
        e_acc   = i_item.sof ? 32'd0 : r_acc;
        e_match = i_item.sof ? 1'b1  : r_match;
        e_rem   = i_item.sof ? 31'd0 : r_rem;

        w_le_acc  = e_acc | ({24'd0, i_item.data} << {e_pos, 3'b000});
        // tail is "ata": middle byte is 't'
        w_tail_ok = (e_pos == 2'd2) ? i_item.eq_t : i_item.eq_a;

        n_state = e_state;
        n_fld   = e_fld;
        n_pos   = e_pos;
        n_acc   = e_acc;
        n_match = e_match;
        n_rem   = e_rem;
        n_held  = r_held;
        w_emit  = 1'b0;
        w_res   = '0;

        unique case (e_state)
            S_HDR: begin
                n_acc = fld_is_tag(e_fld) ? {e_acc[23:0], i_item.data} : w_le_acc;
                if (e_pos == (fld_is_short(e_fld) ? 2'd1 : 2'd3)) begin
                    w_emit            = 1'b1;
                    w_res.kind        = KIND_HEADER;
                    w_res.field_id    = e_fld;
                    w_res.field_value = n_acc;
                    n_acc             = 32'd0;
                    n_pos             = 2'd0;
                    n_fld             = e_fld + 4'd1;
                    if (e_fld == FLD_LAST_FIXED) begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_pos = e_pos + 2'd1;
                end
            end
            S_SCAN: begin
                if (e_pos == 2'd0) begin
                    if (i_item.is_d) begin
                        n_pos   = 2'd1;
                        n_match = 1'b1;
                    end
                end else if (e_pos != 2'd3) begin
                    n_pos   = e_pos + 2'd1;
                    n_match = e_match && w_tail_ok;
                end else begin
                    n_pos   = 2'd0;
                    n_match = 1'b1;
                    if (e_match && w_tail_ok) begin
                        w_emit            = 1'b1;
                        w_res.kind        = KIND_HEADER;
                        w_res.field_id    = FLD_DATA_TAG;
                        w_res.field_value = DATA_TAG;
                        n_acc             = 32'd0;
                        n_state           = S_DSIZE;
                    end
                end
            end
            S_DSIZE: begin
                n_acc = w_le_acc;
                if (e_pos == 2'd3) begin
                    w_emit            = 1'b1;
                    w_res.kind        = KIND_HEADER;
                    w_res.field_id    = FLD_DATA_SIZE;
                    w_res.field_value = w_le_acc;
                    n_rem             = w_le_acc[31:1];
                    n_acc             = 32'd0;
                    n_pos             = 2'd0;
                    n_state           = (w_le_acc[31:1] != 31'd0) ? S_SAMP : S_DONE;
                end else begin
                    n_pos = e_pos + 2'd1;
                end
            end
            S_SAMP: begin
                if (e_pos == 2'd0) begin
                    n_held = i_item.data;
                    n_pos  = 2'd1;
                end else begin
                    w_emit             = 1'b1;
                    w_res.kind         = KIND_SAMPLE;
                    w_res.sample_value = {i_item.data, r_held};
                    w_res.last_sample  = (e_rem == 31'd1);
                    n_pos              = 2'd0;
                    n_rem              = e_rem - 31'd1;
                    if (e_rem == 31'd1) begin
                        n_state = S_DONE;
                    end
                end
            end
            default: begin
                // done: bytes are dropped until the next file start
            end
        endcase
    end

    assign o_res_valid = o_take && w_emit;
    assign o_res       = w_res;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR;
            r_fld   <= 4'd0;
            r_pos   <= 2'd0;
            r_acc   <= 32'd0;
            r_match <= 1'b1;
            r_rem   <= 31'd0;
        end else if (o_take) begin
            r_state <= n_state;
            r_fld   <= n_fld;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_match <= n_match;
            r_rem   <= n_rem;
        end
    end

endmodule

// File: design/wav_header_and_sample_parser_unit.sv
// Path: a pushed byte is registered in the input queue; the back end parses it
// combinationally and writes the result it completes into the result queue.
// Throughput: one byte per cycle unless stalled, set by the combinational parse step.
// The back end stalls while the 2-entry result queue is full and not popped; the input
// side goes full once the 2-entry input queue backs up behind it.
// Reset: synchronous, active low; empties both queues and restarts at the RIFF tag.
module wav_header_and_sample_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_start_of_file,
    output logic               empty,
    input  logic               pop,
    output logic               o_result_kind,
    output logic [3:0]         o_field_id,
    output logic [31:0]        o_field_value,
    output logic signed [15:0] o_sample_value,
    output logic               o_last_sample
);
    import wavp_pkg::*;

`include "wav_header_and_sample_parser_unit_macros.svh"

    logic    w_q_valid, w_q_take;
    t_item   w_q_item;
    logic    w_res_valid, w_oq_full;
    t_result w_res, w_head;

    wavp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_full          (full),
        .o_valid         (w_q_valid),
        .o_item          (w_q_item),
        .i_take          (w_q_take)
    );

    wavp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_take      (w_q_take),
        .i_out_ready (!w_oq_full || (pop && !empty)),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wavp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_res   (w_res),
        .o_full  (w_oq_full),
        .o_empty (empty),
        .o_head  (w_head),
        .i_pop   (pop)
    );

    assign o_result_kind  = w_head.kind;
    assign o_field_id     = w_head.field_id;
    assign o_field_value  = w_head.field_value;
    assign o_sample_value = w_head.sample_value;
    assign o_last_sample  = w_head.last_sample;

    `WAVP_ASSERT_NOW(a_no_take_when_blocked, w_oq_full && !pop && w_q_valid, !w_q_take,
        "back end consumed a byte with the result queue full")
    `WAVP_ASSERT_NOW(a_header_clean, !empty && (o_result_kind == KIND_HEADER),
        (o_sample_value == 16'sd0) && !o_last_sample && (o_field_id <= FLD_DATA_SIZE),
        "malformed header transaction")
    `WAVP_ASSERT_NOW(a_sample_clean, !empty && (o_result_kind == KIND_SAMPLE),
        (o_field_id == 4'd0) && (o_field_value == 32'd0),
        "sample transaction carries header data")
    `WAVP_ASSERT_NEXT(a_result_lands, w_res_valid, !empty,
        "result lost on its way to the result queue")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import wavp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int          ITEM_TARGET = 1650;

    // parser phases past the fixed header fields (0..10 are the fields themselves)
    localparam logic [3:0] PH_SCAN = 4'd11;
    localparam logic [3:0] PH_SIZE = 4'd12;
    localparam logic [3:0] PH_SAMP = 4'd13;
    localparam logic [3:0] PH_DONE = 4'd14;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666d7420;

    // bit n set: header field n is a big-endian tag / a two-byte number
    localparam logic [10:0] TAG_FIELDS   = 11'b000_0000_1101;
    localparam logic [10:0] SHORT_FIELDS = 11'b110_0110_0000;

    typedef struct {
        logic [7:0] data;
        logic       sof;
        bit         drain;
    } t_stream_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_start_of_file = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_result_kind;
    logic [3:0]         o_field_id;
    logic [31:0]        o_field_value;
    logic signed [15:0] o_sample_value;
    logic               o_last_sample;

    wav_header_and_sample_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .empty           (empty),
        .pop             (pop),
        .o_result_kind   (o_result_kind),
        .o_field_id      (o_field_id),
        .o_field_value   (o_field_value),
        .o_sample_value  (o_sample_value),
        .o_last_sample   (o_last_sample)
    );

    always #5 i_clk = ~i_clk;

    t_stream_byte pend_q[$];
    t_result      exp_q[$];
    logic [7:0]   file_bytes[$];

    int          useful = 0;
    int          errors = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          pop_mode = 0;
    int          mode_left = 0;
    int unsigned cycles = 0;
    t_result     want;

    // parser image
    logic [3:0]  ph;
    logic [1:0]  pos;
    logic [31:0] acc;
    logic        tag_ok;
    logic [30:0] remaining;
    logic [7:0]  low_byte;

    function automatic void parser_clear();
        ph = 4'd0;
        pos = 2'd0;
        acc = 32'd0;
        tag_ok = 1'b1;
        remaining = 31'd0;
        low_byte = 8'd0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic sof);
        t_result r;
        bit      got;
        r = '0;
        got = 0;
        if (sof)
            parser_clear();
        if (ph <= FLD_LAST_FIXED) begin
            if (TAG_FIELDS[ph])
                acc = {acc[23:0], b};
            else
                acc = acc | ({24'd0, b} << {pos, 3'b000});
            if (pos == 2'd3 || (SHORT_FIELDS[ph] && pos == 2'd1)) begin
                r.kind = KIND_HEADER;
                r.field_id = ph;
                r.field_value = acc;
                got = 1;
                acc = 32'd0;
                pos = 2'd0;
                ph = ph + 4'd1;
            end else begin
                pos = pos + 2'd1;
            end
        end else if (ph == PH_SCAN) begin
            if (pos == 2'd0) begin
                if (b == CH_D) begin
                    pos = 2'd1;
                    tag_ok = 1'b1;
                end
            end else begin
                if (b != ((pos == 2'd2) ? CH_T : CH_A))
                    tag_ok = 1'b0;
                if (pos != 2'd3) begin
                    pos = pos + 2'd1;
                end else begin
                    pos = 2'd0;
                    if (tag_ok) begin
                        acc = 32'd0;
                        ph = PH_SIZE;
                        r.kind = KIND_HEADER;
                        r.field_id = FLD_DATA_TAG;
                        r.field_value = DATA_TAG;
                        got = 1;
                    end else begin
                        tag_ok = 1'b1;
                    end
                end
            end
        end else if (ph == PH_SIZE) begin
            acc = acc | ({24'd0, b} << {pos, 3'b000});
            if (pos == 2'd3) begin
                r.kind = KIND_HEADER;
                r.field_id = FLD_DATA_SIZE;
                r.field_value = acc;
                got = 1;
                remaining = acc[31:1];
                acc = 32'd0;
                pos = 2'd0;
                ph = (remaining != 31'd0) ? PH_SAMP : PH_DONE;
            end else begin
                pos = pos + 2'd1;
            end
        end else if (ph == PH_SAMP) begin
            if (pos == 2'd0) begin
                low_byte = b;
                pos = 2'd1;
            end else begin
                pos = 2'd0;
                remaining = remaining - 31'd1;
                r.kind = KIND_SAMPLE;
                r.sample_value = {b, low_byte};
                r.last_sample = (remaining == 31'd0);
                got = 1;
                if (r.last_sample)
                    ph = PH_DONE;
            end
        end
        // anything else (done or unused phase): byte is dropped
        if (got)
            exp_q.insert(exp_q.size(), r);
    endfunction

    // stimulus construction
    function automatic void add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic logic [31:0] pick_num(input int mode);
        if (mode == 1)
            return 32'd0;
        if (mode == 2 || $urandom_range(0, 9) == 0)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic put_be(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            add_byte(v[8*i +: 8]);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            add_byte(v[8*i +: 8]);
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic build_header(input int mode, input bit real_tags);
        put_be(real_tags ? TAG_RIFF : pick_num(mode));
        put_le(pick_num(mode), 4);
        put_be(real_tags ? TAG_WAVE : pick_num(mode));
        put_be(real_tags ? TAG_FMT : pick_num(mode));
        put_le(pick_num(mode), 4);
        put_le(pick_num(mode), 2);
        put_le(pick_num(mode), 2);
        put_le(pick_num(mode), 4);
        put_le(pick_num(mode), 4);
        put_le(pick_num(mode), 2);
        put_le(pick_num(mode), 2);
    endtask

    // bytes between the fmt block and the data tag, including near misses
    task automatic add_junk(input int segs);
        logic [7:0] b;
        logic [7:0] tail[3];
        int         bad;
        for (int s = 0; s < segs; s++) begin
            case ($urandom_range(0, 2))
                0: begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_D)
                        b = b ^ 8'h01;
                    add_byte(b);
                end
                1: begin
                    tail[0] = CH_A;
                    tail[1] = CH_T;
                    tail[2] = CH_A;
                    bad = $urandom_range(0, 2);
                    tail[bad] = tail[bad] ^ 8'($urandom_range(1, 255));
                    add_byte(CH_D);
                    for (int i = 0; i < 3; i++)
                        add_byte(tail[i]);
                end
                default: begin
                    // "ddat" swallows the second d, then the trailing "t" is plain scan
                    add_byte(CH_D);
                    put_be(DATA_TAG);
                    file_bytes[file_bytes.size()-1] = CH_D ^ 8'h10;
                end
            endcase
        end
    endtask

    task automatic queue_file(input bit sof, input bit drain, input int keep,
                              input int n_ignored);
        t_stream_byte it;
        int           live;
        live = file_bytes.size() - n_ignored;
        for (int i = 0; i < keep; i++) begin
            it.data = file_bytes[i];
            it.sof = sof && (i == 0);
            it.drain = drain && (i == 0);
            pend_q.insert(pend_q.size(), it);
        end
        useful += (keep < live) ? keep : live;
        file_bytes.delete();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_byte(i_data_byte, i_start_of_file);
                void'(pend_q.pop_front());
            end
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (pend_q.size() == 0 ||
                             (pend_q[0].drain && exp_q.size() != 0)) begin
                    push <= 1'b0;
                end else begin
                    push <= 1'b1;
                    i_data_byte <= pend_q[0].data;
                    i_start_of_file <= pend_q[0].sof;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    task automatic flag_mismatch(input string what, input t_result w);
        errors++;
        if (errors <= 10)
            $display("%s: expected kind=%0d id=%0d value=%h sample=%h last=%0d,",
                     what, w.kind, w.field_id, w.field_value, w.sample_value,
                     w.last_sample,
                     " got kind=%0d id=%0d value=%h sample=%h last=%0d",
                     o_result_kind, o_field_id, o_field_value, o_sample_value,
                     o_last_sample);
    endtask

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (exp_q.size() == 0) begin
                    flag_mismatch("unexpected transaction", '0);
                end else begin
                    want = exp_q.pop_front();
                    if (o_result_kind !== want.kind || o_field_id !== want.field_id ||
                        o_field_value !== want.field_value ||
                        o_sample_value !== want.sample_value ||
                        o_last_sample !== want.last_sample)
                        flag_mismatch("mismatch", want);
                end
            end
            if (mode_left == 0) begin
                pop_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            case (pop_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 7) == 0);
                default: pop <= cycles[3];
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** wav_header_and_sample_parser_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        int           size;
        int           body;
        int           trailing;
        int           k;
        int           keep;
        t_stream_byte sb;

        parser_clear();

        // no start flag after reset; all-ones numbers; "ddata" misses, then empty chunk
        build_header(2, 1);
        add_byte(CH_D);
        put_be(DATA_TAG);
        put_be(DATA_TAG);
        put_le(32'd0, 4);
        put_random(2);
        queue_file(0, 0, file_bytes.size(), 2);

        // zero numbers, zero tags, broken tag tail, one-byte data chunk
        build_header(1, 0);
        add_byte(CH_D);
        add_byte(CH_A);
        add_byte(CH_T);
        add_byte(8'h41);
        put_be(DATA_TAG);
        put_le(32'd1, 4);
        put_random(1);
        queue_file(1, 0, file_bytes.size(), 1);

        // sample extremes, odd trailing byte; sender waits for the pipe to drain first
        build_header(0, 1);
        put_be(DATA_TAG);
        put_le(32'd5, 4);
        put_le(32'h7FFF_8000, 4);
        put_random(3);
        queue_file(1, 1, file_bytes.size(), 3);

        // restart inside the header, then a huge chunk cut short by the next file
        build_header(0, 1);
        queue_file(1, 0, 10, 0);
        build_header(2, 1);
        put_be(DATA_TAG);
        put_le(32'hFFFF_FFFF, 4);
        put_random(6);
        queue_file(1, 0, file_bytes.size(), 0);

        while (useful < ITEM_TARGET) begin
            k = $urandom_range(0, 9);
            if (k < 8) begin
                build_header(($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0,
                             $urandom_range(0, 7) != 0);
                add_junk($urandom_range(0, 3));
                put_be(DATA_TAG);
                if ($urandom_range(0, 15) == 0) begin
                    size = $urandom | 32'h0000_1000;
                    body = $urandom_range(0, 30);
                    trailing = 0;
                end else begin
                    size = $urandom_range(0, 48);
                    body = size;
                    trailing = $urandom_range(0, 3);
                end
                put_le(size, 4);
                put_random(body + trailing);
                keep = (k == 7) ? $urandom_range(1, file_bytes.size()) : file_bytes.size();
                queue_file(1, $urandom_range(0, 19) == 0, keep, trailing + (body % 2));
            end else begin
                put_random($urandom_range(1, 12));
                keep = file_bytes.size();
                for (int i = 0; i < keep; i++) begin
                    sb.data = file_bytes[i];
                    sb.sof = ($urandom_range(0, 5) == 0);
                    sb.drain = 1'b0;
                    pend_q.insert(pend_q.size(), sb);
                end
                useful += keep;
                file_bytes.delete();
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || push)
            @(posedge i_clk);
        while (exp_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0 && exp_q.size() == 0)
            $display("** wav_header_and_sample_parser_unit: PASSED **");
        else
            $display("** wav_header_and_sample_parser_unit: FAILED **");
        $finish;
    end

endmodule
